>>> hdl/dstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline slot timer table package
// Sizes, codes and the record types shared by the slot ring, the stopwatch
// bank and the top level.
// ----------------------------------------------------------------------------
package dstt_pkg;

    localparam int DEADLINE_SLOTS = 8;
    localparam int STOPWATCHES    = 8;
    localparam int MAX_RESULTS    = 8;

    localparam int SLOT_IW  = (DEADLINE_SLOTS > 1) ? $clog2(DEADLINE_SLOTS) : 1;
    localparam int WATCH_IW = (STOPWATCHES > 1) ? $clog2(STOPWATCHES) : 1;
    localparam int FIRE_CW  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_START  = 3'd3,
        ACT_STOP   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_STARTED = 3'd4,
        KIND_BUSY    = 3'd5,
        KIND_STOPPED = 3'd6
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic        active;
        logic        wrap;
        logic        due;
        logic [31:0] deadline;
        logic [31:0] handler;
        logic [31:0] tag;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic add;
        logic remove;
        logic tick;
        logic wrap_clr;
    } cell_ctl_t;

    typedef struct packed {
        logic                start;
        logic                stop;
        logic [WATCH_IW-1:0] sel;
    } watch_ctl_t;

endpackage
`default_nettype wire

>>> hdl/dstt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline slot cell
// Holds one deadline slot, evaluates it on a tick and passes it to its
// neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module dstt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dstt_pkg::cell_ctl_t ctl,
    input  dstt_pkg::slot_t    add_data,
    input  dstt_pkg::slot_t    nb_in,
    input  logic [31:0]        now_next,
    output dstt_pkg::slot_t    slot_q
);
    import dstt_pkg::*;

    logic        active_reg, active_next;
    logic        wrap_reg, wrap_next;
    logic        due_reg, due_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] handler_reg, handler_next;
    logic [31:0] tag_reg, tag_next;

    always_comb
    begin
        active_next   = active_reg;
        wrap_next     = wrap_reg;
        due_next      = due_reg;
        deadline_next = deadline_reg;
        handler_next  = handler_reg;
        tag_next      = tag_reg;
        if (ctl.shift)
        begin
            active_next   = nb_in.active;
            wrap_next     = nb_in.wrap;
            due_next      = nb_in.due;
            deadline_next = nb_in.deadline;
            handler_next  = nb_in.handler;
            tag_next      = nb_in.tag;
        end
        else if (ctl.add)
        begin
            active_next   = add_data.active;
            wrap_next     = add_data.wrap;
            due_next      = add_data.due;
            deadline_next = add_data.deadline;
            handler_next  = add_data.handler;
            tag_next      = add_data.tag;
        end
        else if (ctl.remove)
        begin
            active_next = 1'b0;
        end
        else if (ctl.tick)
        begin
            wrap_next = wrap_reg & ~ctl.wrap_clr;
            due_next  = active_reg & ~wrap_next & (deadline_reg <= now_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wrap_reg   <= 1'b0;
            due_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            wrap_reg   <= wrap_next;
            due_reg    <= due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        handler_reg  <= handler_next;
        tag_reg      <= tag_next;
    end

    assign slot_q = '{active:   active_reg,
                      wrap:     wrap_reg,
                      due:      due_reg,
                      deadline: deadline_reg,
                      handler:  handler_reg,
                      tag:      tag_reg};

endmodule
`default_nettype wire

>>> hdl/dstt_watch_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch bank
// Stores a start count and a running flag per stopwatch and returns the
// difference to the current count on stop.
// ----------------------------------------------------------------------------
module dstt_watch_bank (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dstt_pkg::watch_ctl_t ctl,
    input  logic [31:0]          now,
    output logic                 start_ok,
    output logic [31:0]          elapsed
);
    import dstt_pkg::*;

    logic [31:0]      value_reg   [STOPWATCHES];
    logic [31:0]      value_next  [STOPWATCHES];
    logic [STOPWATCHES-1:0] running_reg, running_next;

    assign start_ok = ~running_reg[ctl.sel];
    assign elapsed  = now - value_reg[ctl.sel];

    always_comb
    begin
        running_next = running_reg;
        for (int w = 0; w < STOPWATCHES; w++)
        begin
            value_next[w] = value_reg[w];
        end
        if (ctl.start && start_ok)
        begin
            value_next[ctl.sel]   = now;
            running_next[ctl.sel] = 1'b1;
        end
        else if (ctl.stop)
        begin
            value_next[ctl.sel]   = elapsed;
            running_next[ctl.sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            for (int w = 0; w < STOPWATCHES; w++)
            begin
                value_reg[w] <= '0;
            end
        end
        else
        begin
            running_reg <= running_next;
            for (int w = 0; w < STOPWATCHES; w++)
            begin
                value_reg[w] <= value_next[w];
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/deadline_slot_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline slot timer table
// Millisecond count, a ring of one-shot deadline slot cells and a bank of
// stopwatches.
//
// Channel | Dir | Handshake           | Beat
// input   | in  | in_valid, in_ready  | action, offset, slot, handler, tag
// output  | out | out_valid, out_ready| kind, slot_index, fired_handler,
//         |     |                     | fired_tag, elapsed, last
//
// Add, remove, start and stop each give one registered beat.
// A tick marks the due slots, then the slot ring rotates one cell per cycle
// while not held, past the head cell, which emits any due slot.
// A fire that meets a full output register holds the ring for that cycle.
// Reset clears the count, the slot flags and the stopwatches; no clearing pass.
// ----------------------------------------------------------------------------
module deadline_slot_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] offset,
    input  logic [2:0]  slot,
    input  logic [31:0] handler,
    input  logic [31:0] tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [2:0]  slot_index,
    output logic [31:0] fired_handler,
    output logic [31:0] fired_tag,
    output logic [31:0] elapsed,
    output logic        last
);
    import dstt_pkg::*;

    state_t              state_reg, state_next;
    logic [31:0]         now_reg, now_next;
    logic [SLOT_IW-1:0]  step_reg, step_next;
    logic [FIRE_CW-1:0]  fires_reg, fires_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          kind_reg, kind_next;
    logic [2:0]          idx_reg, idx_next;
    logic [31:0]         handler_reg, handler_next;
    logic [31:0]         tag_reg, tag_next;
    logic [31:0]         elapsed_reg, elapsed_next;
    logic                last_reg, last_next;

    slot_t               cell_q  [DEADLINE_SLOTS];
    slot_t               nb      [DEADLINE_SLOTS];
    cell_ctl_t           ctl     [DEADLINE_SLOTS];
    slot_t               ring_in;
    slot_t               add_data;
    logic [32:0]         add_sum;

    logic                accept, out_free, is_tick, last_step;
    logic                scan_shift, emit, fire_ok, later_due, due_any;
    logic                free_found;
    logic [SLOT_IW-1:0]  free_idx;
    logic                sw_in_range, start_ok;
    logic [31:0]         watch_elapsed;
    watch_ctl_t          wctl;

    assign out_free  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;
    assign is_tick   = (action == ACT_TICK);
    assign now_next  = now_reg + 32'd1;
    assign last_step = (step_reg == SLOT_IW'(DEADLINE_SLOTS - 1));
    assign fire_ok   = cell_q[0].due & (fires_reg < FIRE_CW'(MAX_RESULTS));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_tick)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_shift && last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        emit       = 1'b0;
        scan_shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
            end
            ST_SCAN:
            begin
                emit       = fire_ok & out_free;
                scan_shift = ~(fire_ok & ~out_free);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = DEADLINE_SLOTS - 1; j >= 0; j--)
        begin
            if (!cell_q[j].active)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_IW'(j);
            end
        end
    end

    always_comb
    begin
        later_due = 1'b0;
        due_any   = 1'b0;
        for (int p = 0; p < DEADLINE_SLOTS; p++)
        begin
            due_any = due_any | cell_q[p].due;
            if (p >= 1 && (p + int'(step_reg)) < DEADLINE_SLOTS)
            begin
                later_due = later_due | cell_q[p].due;
            end
        end
    end

    assign add_sum  = {1'b0, now_reg} + {1'b0, offset};
    assign add_data = '{active:   1'b1,
                        wrap:     add_sum[32],
                        due:      1'b0,
                        deadline: add_sum[31:0],
                        handler:  handler,
                        tag:      tag};

    always_comb
    begin
        ring_in        = cell_q[0];
        ring_in.due    = 1'b0;
        ring_in.active = cell_q[0].active & ~emit;
    end

    always_comb
    begin
        for (int j = 0; j < DEADLINE_SLOTS; j++)
        begin
            ctl[j].shift    = scan_shift;
            ctl[j].add      = accept & (action == ACT_ADD) & free_found &
                              (free_idx == SLOT_IW'(j));
            ctl[j].remove   = accept & (action == ACT_REMOVE) & (int'(slot) == j);
            ctl[j].tick     = accept & is_tick;
            ctl[j].wrap_clr = (now_next == 32'd0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEADLINE_SLOTS; g++)
        begin : g_cell
            if (g == DEADLINE_SLOTS - 1)
            begin : g_tail
                assign nb[g] = ring_in;
            end
            else
            begin : g_body
                assign nb[g] = cell_q[g + 1];
            end
            dstt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[g]),
                .add_data (add_data),
                .nb_in    (nb[g]),
                .now_next (now_next),
                .slot_q   (cell_q[g])
            );
        end
    endgenerate

    assign sw_in_range = (int'(slot) < STOPWATCHES);
    assign wctl.sel    = WATCH_IW'(slot);
    assign wctl.start  = accept & (action == ACT_START) & sw_in_range;
    assign wctl.stop   = accept & (action == ACT_STOP) & sw_in_range;

    dstt_watch_bank u_watch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (wctl),
        .now      (now_reg),
        .start_ok (start_ok),
        .elapsed  (watch_elapsed)
    );

    always_comb
    begin
        step_next  = step_reg;
        fires_next = fires_reg;
        if (accept && is_tick)
        begin
            step_next  = '0;
            fires_next = '0;
        end
        else
        begin
            if (scan_shift)
            begin
                step_next = step_reg + SLOT_IW'(1);
            end
            if (emit)
            begin
                fires_next = fires_reg + FIRE_CW'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        handler_next   = handler_reg;
        tag_next       = tag_reg;
        elapsed_next   = elapsed_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_FIRED;
            idx_next       = 3'(step_reg);
            handler_next   = cell_q[0].handler;
            tag_next       = cell_q[0].tag;
            elapsed_next   = '0;
            last_next      = (fires_reg == FIRE_CW'(MAX_RESULTS - 1)) | ~later_due;
        end
        else if (accept && action inside {ACT_ADD, ACT_REMOVE, ACT_START, ACT_STOP})
        begin
            out_valid_next = 1'b1;
            idx_next       = slot;
            handler_next   = '0;
            tag_next       = '0;
            elapsed_next   = '0;
            last_next      = 1'b1;
            case (action)
                ACT_ADD:
                begin
                    kind_next = free_found ? KIND_ADDED : KIND_FULL;
                    idx_next  = free_found ? 3'(free_idx) : 3'd0;
                end
                ACT_REMOVE:
                begin
                    kind_next = KIND_REMOVED;
                end
                ACT_START:
                begin
                    kind_next = (sw_in_range && start_ok) ? KIND_STARTED : KIND_BUSY;
                end
                ACT_STOP:
                begin
                    kind_next    = KIND_STOPPED;
                    elapsed_next = sw_in_range ? watch_elapsed : 32'd0;
                end
                default:
                begin
                    kind_next = kind_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            step_reg      <= '0;
            fires_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= (accept && is_tick) ? now_next : now_reg;
            step_reg      <= step_next;
            fires_reg     <= fires_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        idx_reg     <= idx_next;
        handler_reg <= handler_next;
        tag_reg     <= tag_next;
        elapsed_reg <= elapsed_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign slot_index    = idx_reg;
    assign fired_handler = handler_reg;
    assign fired_tag     = tag_reg;
    assign elapsed       = elapsed_reg;
    assign last          = last_reg;

    a_fire_beat: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && kind_reg == KIND_FIRED))
        else $error("fire did not reach the output register");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FIRE_CW'(MAX_RESULTS))
        else $error("fire count above limit");

    a_idle_no_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !due_any)
        else $error("due mark left after scan");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick) |=> (now_reg == $past(now_reg) + 32'd1))
        else $error("tick did not advance the count");

endmodule
`default_nettype wire
